FILE: rtl/c3a_pkg.sv
// Shared types, widths and register codes of the 3x3 convolution block.
package c3a_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 11;
   localparam int CMP_W      = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
   localparam int MIN_DIM    = 3;

   localparam int PIX_W      = 16;
   localparam int PSUM_W     = 40;
   localparam int PROD_W     = 2 * PIX_W;
   localparam int ROWSUM_W   = PROD_W + 2;
   localparam int TOT_W      = PSUM_W + 2;
   localparam int COORD_W    = 10;
   localparam int WROW_W     = 3 * PIX_W;
   localparam int TAPS       = 3;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACCUMULATE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEND_TO_LOCAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHTS_TOP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHTS_MID   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHTS_BOT   = 3'd6;

   typedef struct packed {
      logic signed [PIX_W-1:0]  pixel_value;
      logic signed [PSUM_W-1:0] partial_sum;
   } c3a_req_type;

   typedef struct packed {
      logic signed [PSUM_W-1:0] window_sum;
      logic [COORD_W-1:0]       out_row;
      logic [COORD_W-1:0]       out_col;
      logic                     to_local_store;
      logic                     last_of_frame;
   } c3a_rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
   } c3a_cell_ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0]         pixel;
      logic signed [PSUM_W-1:0] psum;
      logic [COL_W-1:0]         slot;
      logic                     produce;
      logic [COORD_W-1:0]       out_row;
      logic [COORD_W-1:0]       out_col;
      logic                     last;
   } c3a_meta_type;

endpackage

FILE: rtl/conv3x3_valid_accumulate.sv
// Top level: 3x3 valid-region convolution over a raster pixel stream with optional accumulation.
//
//   channel   ports                         direction   transfer when
//   req       req_valid/req_stall/req_data  in          req_valid & !req_stall
//   rsp       rsp_valid/rsp_stall/rsp_data  out         rsp_valid & !rsp_stall
//   csr       psel/penable/pwrite/paddr...  in/out      psel & penable & pwrite (write)
//
// One pixel per cycle sustained while rsp_stall does not back up the stages; a result is
// registered in turn through line-store read, window cells, products, row sums, total and saturation.
// The two line stores take one read and one write per cycle each.
// Synchronous active-high reset clears counters and stage valids and resets the configuration registers.
// Stages are elastic: bubbles are squeezed out, so pixels that give no result
// keep moving while a result waits on rsp_stall.
module conv3x3_valid_accumulate import c3a_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  c3a_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output c3a_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration
   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic              acc_ff, acc_in;
   logic              local_ff, local_in;
   logic [WROW_W-1:0] wrow_ff [TAPS];
   logic [WROW_W-1:0] wrow_in [TAPS];
   logic [CSR_IDX_W-1:0] csr_idx;
   logic              csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign csr_wr  = psel & penable & pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      acc_in    = acc_ff;
      local_in  = local_ff;
      for (int r = 0; r < TAPS; r++) begin
         wrow_in[r] = wrow_ff[r];
      end
      if (csr_wr) begin
         unique case (csr_idx)
            REG_IMAGE_WIDTH:   width_in   = pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  height_in  = pwdata[DIM_W-1:0];
            REG_ACCUMULATE:    acc_in     = pwdata[0];
            REG_SEND_TO_LOCAL: local_in   = pwdata[0];
            REG_WEIGHTS_TOP:   wrow_in[0] = pwdata[WROW_W-1:0];
            REG_WEIGHTS_MID:   wrow_in[1] = pwdata[WROW_W-1:0];
            REG_WEIGHTS_BOT:   wrow_in[2] = pwdata[WROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_IMAGE_WIDTH:   prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT:  prdata = CSR_DATA_W'(height_ff);
         REG_ACCUMULATE:    prdata = CSR_DATA_W'(acc_ff);
         REG_SEND_TO_LOCAL: prdata = CSR_DATA_W'(local_ff);
         REG_WEIGHTS_TOP:   prdata = CSR_DATA_W'(wrow_ff[0]);
         REG_WEIGHTS_MID:   prdata = CSR_DATA_W'(wrow_ff[1]);
         REG_WEIGHTS_BOT:   prdata = CSR_DATA_W'(wrow_ff[2]);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(MAX_WIDTH);
         height_ff <= DIM_W'(MAX_HEIGHT);
         acc_ff    <= 1'b0;
         local_ff  <= 1'b0;
         for (int r = 0; r < TAPS; r++) begin
            wrow_ff[r] <= '0;
         end
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         acc_ff    <= acc_in;
         local_ff  <= local_in;
         for (int r = 0; r < TAPS; r++) begin
            wrow_ff[r] <= wrow_in[r];
         end
      end
   end

   // effective geometry
   logic [CMP_W-1:0] w_ext, h_ext, w_eff, h_eff;

   assign w_ext = CMP_W'(width_ff);
   assign h_ext = CMP_W'(height_ff);
   assign w_eff = (w_ext < CMP_W'(MIN_DIM)) ? CMP_W'(MIN_DIM) :
                  (w_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_ext;
   assign h_eff = (h_ext < CMP_W'(MIN_DIM)) ? CMP_W'(MIN_DIM) :
                  (h_ext > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : h_ext;

   // stage handshake
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in, s4_v_in;
   logic accept, go1, go2, go3, go4, out_free, out_load;
   c3a_meta_type s1_ff, s2_ff, s3_ff, s4_ff;
   c3a_meta_type s1_in, s2_in, s3_in, s4_in;

   logic rsp_valid_ff, rsp_valid_in;
   c3a_rsp_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go4      = s4_v_ff && (!s4_ff.produce || out_free);
   assign go3      = s3_v_ff && (!s4_v_ff || go4);
   assign go2      = s2_v_ff && (!s3_v_ff || go3);
   assign go1      = s1_v_ff && (!s2_v_ff || go2);
   assign req_stall = s1_v_ff && !go1;
   assign accept   = req_valid && !req_stall;
   assign out_load = go4 && s4_ff.produce;

   // position counters
   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic             col_end, row_end;

   assign col_end = (CMP_W'(col_cnt_ff) + CMP_W'(1)) >= w_eff;
   assign row_end = (CMP_W'(row_cnt_ff) + CMP_W'(1)) >= h_eff;

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (col_end) begin
            col_cnt_in = '0;
            row_cnt_in = row_end ? '0 : row_cnt_ff + ROW_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_in.pixel   = req_data.pixel_value;
      s1_in.psum    = req_data.partial_sum;
      s1_in.slot    = col_cnt_ff;
      s1_in.produce = (row_cnt_ff >= ROW_W'(2)) && (col_cnt_ff >= COL_W'(2));
      s1_in.out_row = COORD_W'(row_cnt_ff - ROW_W'(2));
      s1_in.out_col = COORD_W'(col_cnt_ff - COL_W'(2));
      s1_in.last    = row_end && col_end;
   end

   assign s2_in = s1_ff;
   assign s3_in = s2_ff;

   always_comb begin
      s4_in      = s3_ff;
      s4_in.psum = acc_ff ? s3_ff.psum : '0;
   end

   assign s1_v_in = accept || (s1_v_ff && !go1);
   assign s2_v_in = go1 || (s2_v_ff && !go2);
   assign s3_v_in = go2 || (s3_v_ff && !go3);
   assign s4_v_in = go3 || (s4_v_ff && !go4);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         s4_v_ff    <= 1'b0;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
         s3_v_ff    <= s3_v_in;
         s4_v_ff    <= s4_v_in;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (go1) begin
         s2_ff <= s2_in;
      end
      if (go2) begin
         s3_ff <= s3_in;
      end
      if (go3) begin
         s4_ff <= s4_in;
      end
   end

   // line stores: read on transfer, write back when the item enters the window
   logic [PIX_W-1:0] up2, up1;

   c3a_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_older (
      .clock   (clock),
      .wr_en   (go1),
      .wr_addr (s1_ff.slot),
      .wr_data (up1),
      .rd_en   (accept),
      .rd_addr (col_cnt_ff),
      .rd_data (up2)
   );

   c3a_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_newer (
      .clock   (clock),
      .wr_en   (go1),
      .wr_addr (s1_ff.slot),
      .wr_data (s1_ff.pixel),
      .rd_en   (accept),
      .rd_addr (col_cnt_ff),
      .rd_data (up1)
   );

   // window cells: three chains, column 2 newest
   c3a_cell_ctl_type cell_ctl;
   logic [PIX_W-1:0]         row_src [TAPS];
   logic [PIX_W-1:0]         tap     [TAPS][TAPS];
   logic signed [PROD_W-1:0] prod    [TAPS][TAPS];

   assign cell_ctl.shift = go1;
   assign cell_ctl.load  = go2;
   assign row_src[0] = up2;
   assign row_src[1] = up1;
   assign row_src[2] = s1_ff.pixel;

   for (genvar r = 0; r < TAPS; r++) begin : g_row
      for (genvar c = 0; c < TAPS; c++) begin : g_col
         logic [PIX_W-1:0] shift_src;
         if (c == TAPS - 1) begin : g_head
            assign shift_src = row_src[r];
         end else begin : g_link
            assign shift_src = tap[r][c+1];
         end
         c3a_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .shift_data (shift_src),
            .weight     (wrow_ff[r][c*PIX_W +: PIX_W]),
            .tap_out    (tap[r][c]),
            .prod_out   (prod[r][c])
         );
      end
   end

   // row sums
   logic signed [ROWSUM_W-1:0] rsum_ff [TAPS];
   logic signed [ROWSUM_W-1:0] rsum_in [TAPS];

   always_comb begin
      for (int r = 0; r < TAPS; r++) begin
         rsum_in[r] = ROWSUM_W'(prod[r][0]) + ROWSUM_W'(prod[r][1]) + ROWSUM_W'(prod[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (go3) begin
         for (int r = 0; r < TAPS; r++) begin
            rsum_ff[r] <= rsum_in[r];
         end
      end
   end

   // total, saturation and output register
   logic signed [TOT_W-1:0]  total;
   logic signed [PSUM_W-1:0] sat_sum;

   assign total = TOT_W'(rsum_ff[0]) + TOT_W'(rsum_ff[1]) + TOT_W'(rsum_ff[2])
                + TOT_W'(s4_ff.psum);

   always_comb begin
      if (total[TOT_W-1:PSUM_W-1] == '0 || total[TOT_W-1:PSUM_W-1] == '1) begin
         sat_sum = total[PSUM_W-1:0];
      end else if (total[TOT_W-1]) begin
         sat_sum = {1'b1, {(PSUM_W-1){1'b0}}};
      end else begin
         sat_sum = {1'b0, {(PSUM_W-1){1'b1}}};
      end
   end

   always_comb begin
      rsp_data_in.window_sum     = sat_sum;
      rsp_data_in.out_row        = s4_ff.out_row;
      rsp_data_in.out_col        = s4_ff.out_col;
      rsp_data_in.to_local_store = local_ff;
      rsp_data_in.last_of_frame  = s4_ff.last;
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_v_ff)
      else $error("transfer not captured in first stage");

   a_rsp_from_s4: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_v_ff && s4_ff.produce))
      else $error("result raised without a producing item");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && s4_ff.produce && !out_free) |=> (s4_v_ff && s4_ff.produce))
      else $error("pending result dropped");

   a_no_ram_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && go1) |-> (s1_ff.slot != col_cnt_ff))
      else $error("line store read and write at same slot");

endmodule

FILE: rtl/c3a_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c3a_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/c3a_cell.sv
// One window tap: holds a sample, passes it to its older neighbor, registers its product.
module c3a_cell import c3a_pkg::*; (
   input  logic                     clock,
   input  c3a_cell_ctl_type         ctl,
   input  logic [PIX_W-1:0]         shift_data,
   input  logic [PIX_W-1:0]         weight,
   output logic [PIX_W-1:0]         tap_out,
   output logic signed [PROD_W-1:0] prod_out
);

   logic [PIX_W-1:0]         tap_ff;
   logic [PIX_W-1:0]         tap_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PIX_W-1:0]  tap_s;
   logic signed [PIX_W-1:0]  weight_s;
   logic signed [PROD_W-1:0] mult;

   assign tap_s    = $signed(tap_ff);
   assign weight_s = $signed(weight);
   assign mult     = tap_s * weight_s;

   assign tap_in  = ctl.shift ? shift_data : tap_ff;
   assign prod_in = ctl.load ? mult : prod_ff;

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      prod_ff <= prod_in;
   end

   assign tap_out  = tap_ff;
   assign prod_out = prod_ff;

endmodule
